FILE: rtl/assert_macros.svh
// Assertion macros for the line rasterizer RTL.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/alr_pkg.sv
`timescale 1ns / 1ps
package alr_pkg;

    localparam int COORD_BITS = 16;
    localparam int POS_BITS = COORD_BITS + 2;
    localparam int FRAME_BITS = 15;
    localparam int COV_BITS = 9;
    localparam int CFG_INDEX_BITS = 1;
    localparam int DEF_FRAC_BITS = 16;
    localparam int DEF_QUEUE_DEPTH = 2;

    localparam logic [FRAME_BITS-1:0] FRAME_RESET = 15'd1024;
    localparam logic [COV_BITS-1:0] COV_FULL = 9'd256;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic                         kind;
        logic signed [COORD_BITS-1:0] x_start;
        logic signed [COORD_BITS-1:0] y_start;
        logic signed [COORD_BITS-1:0] x_end;
        logic signed [COORD_BITS-1:0] y_end;
    } alr_in_t;

    typedef struct packed {
        logic [FRAME_BITS-1:0] pixel_x;
        logic [FRAME_BITS-1:0] pixel_y;
        logic [COV_BITS-1:0]   coverage;
        logic                  last;
        logic                  line_finished;
    } alr_out_t;

    // Classified command: endpoints in major/minor order, major ascending.
    typedef struct packed {
        logic                         kind;
        logic                         steep;
        logic signed [COORD_BITS-1:0] maj0;
        logic signed [COORD_BITS-1:0] min0;
        logic signed [COORD_BITS-1:0] maj1;
        logic signed [COORD_BITS-1:0] min1;
        logic [COORD_BITS-1:0]        dx;
        logic                         dy_neg;
        logic [COORD_BITS-1:0]        dy_mag;
    } alr_cmd_t;

    // One candidate pixel, already mapped to frame axes and clip-checked.
    typedef struct packed {
        logic                  ok;
        logic [FRAME_BITS-1:0] x;
        logic [FRAME_BITS-1:0] y;
        logic [COV_BITS-1:0]   cov;
        logic                  fin;
    } alr_pix_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } alr_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } alr_queue_stat_t;

    typedef struct packed {
        logic dividing;
        logic loading;
    } alr_back_stat_t;

endpackage

FILE: rtl/alr_front.sv
`timescale 1ns / 1ps
module alr_front (
    input  logic                      in_valid,
    output logic                      in_ready,
    input  alr_pkg::alr_in_t          in_item,
    input  alr_pkg::alr_queue_stat_t  q_stat,
    output logic                      push,
    output alr_pkg::alr_cmd_t         cmd
);
    import alr_pkg::*;

    logic signed [COORD_BITS:0]   dxs;
    logic signed [COORD_BITS:0]   dys;
    logic signed [COORD_BITS:0]   span;
    logic signed [COORD_BITS:0]   rise;
    logic [COORD_BITS-1:0]        adx;
    logic [COORD_BITS-1:0]        ady;
    logic                         steep;
    logic                         swap;
    logic signed [COORD_BITS-1:0] a0;
    logic signed [COORD_BITS-1:0] b0;
    logic signed [COORD_BITS-1:0] a1;
    logic signed [COORD_BITS-1:0] b1;
    logic signed [COORD_BITS-1:0] maj0;
    logic signed [COORD_BITS-1:0] min0;
    logic signed [COORD_BITS-1:0] maj1;
    logic signed [COORD_BITS-1:0] min1;

    assign in_ready = !q_stat.full;
    assign push = in_valid && !q_stat.full;

    always_comb
    begin
        // steep test on the raw endpoint deltas
        dxs = {in_item.x_end[COORD_BITS-1], in_item.x_end}
            - {in_item.x_start[COORD_BITS-1], in_item.x_start};
        dys = {in_item.y_end[COORD_BITS-1], in_item.y_end}
            - {in_item.y_start[COORD_BITS-1], in_item.y_start};
        adx = dxs[COORD_BITS] ? COORD_BITS'(-dxs) : COORD_BITS'(dxs);
        ady = dys[COORD_BITS] ? COORD_BITS'(-dys) : COORD_BITS'(dys);
        steep = ady > adx;

        a0 = steep ? in_item.y_start : in_item.x_start;
        b0 = steep ? in_item.x_start : in_item.y_start;
        a1 = steep ? in_item.y_end : in_item.x_end;
        b1 = steep ? in_item.x_end : in_item.y_end;

        // order endpoints along the major axis
        swap = a0 > a1;
        maj0 = swap ? a1 : a0;
        min0 = swap ? b1 : b0;
        maj1 = swap ? a0 : a1;
        min1 = swap ? b0 : b1;

        span = {maj1[COORD_BITS-1], maj1} - {maj0[COORD_BITS-1], maj0};
        rise = {min1[COORD_BITS-1], min1} - {min0[COORD_BITS-1], min0};

        cmd.kind = in_item.kind;
        cmd.steep = steep;
        cmd.maj0 = maj0;
        cmd.min0 = min0;
        cmd.maj1 = maj1;
        cmd.min1 = min1;
        cmd.dx = COORD_BITS'(span);
        cmd.dy_neg = rise[COORD_BITS];
        cmd.dy_mag = rise[COORD_BITS] ? COORD_BITS'(-rise) : COORD_BITS'(rise);
    end

endmodule

FILE: rtl/alr_queue.sv
`timescale 1ns / 1ps
module alr_queue #(
    parameter int DEPTH = alr_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  alr_pkg::alr_cmd_t         push_cmd,
    input  logic                      pop,
    output alr_pkg::alr_cmd_t         pop_cmd,
    output alr_pkg::alr_queue_stat_t  stat
);
    import alr_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

    alr_cmd_t              slot_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;
    logic                  do_push;
    logic                  do_pop;

    assign stat.full = count_reg == CNT_FULL;
    assign stat.empty = count_reg == '0;
    assign do_push = push && !stat.full;
    assign do_pop = pop && !stat.empty;
    assign pop_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/alr_back.sv
`timescale 1ns / 1ps
module alr_back #(
    parameter int FRAC_BITS = alr_pkg::DEF_FRAC_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [alr_pkg::FRAME_BITS-1:0]     frame_width,
    input  logic [alr_pkg::FRAME_BITS-1:0]     frame_height,
    input  alr_pkg::alr_queue_stat_t           q_stat,
    output logic                               pop,
    input  alr_pkg::alr_cmd_t                  cmd,
    output logic                               out_valid,
    input  logic                               out_ready,
    output alr_pkg::alr_out_t                  out_item,
    output alr_pkg::alr_back_stat_t            stat
);
    import alr_pkg::*;

    localparam int ACC_BITS = POS_BITS + FRAC_BITS;
    localparam int SLOPE_BITS = FRAC_BITS + 2;
    localparam int CNT_BITS = $clog2(FRAC_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(FRAC_BITS - 1);

    function automatic logic signed [POS_BITS-1:0] ext_pos(
        input logic signed [COORD_BITS-1:0] v
    );
        return {{(POS_BITS - COORD_BITS){v[COORD_BITS-1]}}, v};
    endfunction

    // Map major/minor to frame axes and flag anything off the frame.
    function automatic alr_pix_t make_pix(
        input logic                       steep,
        input logic signed [POS_BITS-1:0] major,
        input logic signed [POS_BITS-1:0] minor,
        input logic [FRAME_BITS-1:0]      fw,
        input logic [FRAME_BITS-1:0]      fh,
        input logic [COV_BITS-1:0]        cov,
        input logic                       fin
    );
        logic signed [POS_BITS-1:0] px;
        logic signed [POS_BITS-1:0] py;
        alr_pix_t p;
        px = steep ? minor : major;
        py = steep ? major : minor;
        p.ok = !px[POS_BITS-1] && !py[POS_BITS-1]
            && ($unsigned(px) < {{(POS_BITS - FRAME_BITS){1'b0}}, fw})
            && ($unsigned(py) < {{(POS_BITS - FRAME_BITS){1'b0}}, fh});
        p.x = px[FRAME_BITS-1:0];
        p.y = py[FRAME_BITS-1:0];
        p.cov = cov;
        p.fin = fin;
        return p;
    endfunction

    // control state
    alr_state_t                  state_reg;
    alr_state_t                  state_next;
    logic                        sel_reg;
    logic                        sel_next;
    logic                        active_reg;
    logic                        active_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;

    // datapath state
    alr_cmd_t                    cmd_reg;
    alr_cmd_t                    cmd_next;
    logic                        steep_reg;
    logic                        steep_next;
    logic signed [POS_BITS-1:0]  col_now_reg;
    logic signed [POS_BITS-1:0]  col_now_next;
    logic signed [POS_BITS-1:0]  col_stop_reg;
    logic signed [POS_BITS-1:0]  col_stop_next;
    logic signed [ACC_BITS-1:0]  acc_reg;
    logic signed [ACC_BITS-1:0]  acc_next;
    logic signed [SLOPE_BITS-1:0] slope_reg;
    logic signed [SLOPE_BITS-1:0] slope_next;
    logic [COORD_BITS-1:0]       rem_reg;
    logic [COORD_BITS-1:0]       rem_next;
    logic [FRAC_BITS-1:0]        quo_reg;
    logic [FRAC_BITS-1:0]        quo_next;
    logic [CNT_BITS-1:0]         cnt_reg;
    logic [CNT_BITS-1:0]         cnt_next;
    alr_pix_t                    cand_reg [2];
    alr_pix_t                    cand_next [2];
    alr_out_t                    out_item_reg;
    alr_out_t                    out_item_next;

    // divider step
    logic [COORD_BITS:0]         rem_shift;
    logic                        quo_bit;
    logic [COORD_BITS-1:0]       rem_step;
    logic [FRAC_BITS:0]          quo_final;
    logic [SLOPE_BITS-1:0]       slope_mag;
    logic signed [SLOPE_BITS-1:0] slope_fin;
    logic signed [POS_BITS-1:0]  maj0_pos;
    logic signed [POS_BITS-1:0]  min0_pos;
    logic signed [POS_BITS-1:0]  maj1_pos;
    logic signed [POS_BITS-1:0]  min1_pos;
    logic signed [ACC_BITS-1:0]  acc_start;
    logic                        start_fin;

    // advance step
    logic signed [POS_BITS-1:0]  base_lo;
    logic signed [POS_BITS-1:0]  base_hi;
    logic [7:0]                  frac;
    logic                        adv_fin;
    logic signed [ACC_BITS-1:0]  acc_adv;

    // integer gradient bit straight from the queue head
    logic                        head_int;
    logic                        loading;

    assign rem_shift = {rem_reg, 1'b0};
    assign quo_bit = rem_shift >= {1'b0, cmd_reg.dx};
    assign rem_step = quo_bit ? COORD_BITS'(rem_shift - {1'b0, cmd_reg.dx})
                              : rem_shift[COORD_BITS-1:0];
    assign quo_final = {quo_reg, quo_bit};
    assign slope_mag = {1'b0, quo_final};
    assign slope_fin = cmd_reg.dy_neg ? -slope_mag : slope_mag;
    assign maj0_pos = ext_pos(cmd_reg.maj0);
    assign min0_pos = ext_pos(cmd_reg.min0);
    assign maj1_pos = ext_pos(cmd_reg.maj1);
    assign min1_pos = ext_pos(cmd_reg.min1);
    assign acc_start = {min0_pos, FRAC_BITS'(0)}
        + {{(ACC_BITS - SLOPE_BITS){slope_fin[SLOPE_BITS-1]}}, slope_fin};
    assign start_fin = !(cmd_reg.dx > COORD_BITS'(1));

    assign base_lo = acc_reg[ACC_BITS-1:FRAC_BITS];
    assign base_hi = base_lo + POS_BITS'(1);
    assign frac = acc_reg[FRAC_BITS-1 -: 8];
    assign adv_fin = col_now_reg >= col_stop_reg;
    assign acc_adv = acc_reg
        + {{(ACC_BITS - SLOPE_BITS){slope_reg[SLOPE_BITS-1]}}, slope_reg};

    assign head_int = cmd.dy_mag >= cmd.dx;

    assign out_valid = out_valid_reg;
    assign out_item = out_item_reg;
    assign stat.dividing = state_reg == ST_DIV;
    assign stat.loading = loading;

    always_comb
    begin
        state_next = state_reg;
        sel_next = sel_reg;
        active_next = active_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd_next = cmd_reg;
        steep_next = steep_reg;
        col_now_next = col_now_reg;
        col_stop_next = col_stop_reg;
        acc_next = acc_reg;
        slope_next = slope_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        cand_next = cand_reg;
        out_item_next = out_item_reg;
        pop = 1'b0;
        loading = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop = 1'b1;
                    if (cmd.kind == KIND_START)
                    begin
                        cmd_next = cmd;
                        steep_next = cmd.steep;
                        if (cmd.dx == '0)
                        begin
                            // zero-length line: one point, nothing to walk
                            active_next = 1'b0;
                            cand_next[0] = make_pix(cmd.steep, ext_pos(cmd.maj0),
                                ext_pos(cmd.min0), frame_width, frame_height,
                                COV_FULL, 1'b1);
                            cand_next[1] = '0;
                            sel_next = 1'b0;
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            // integer bit of the gradient, then fraction bits serially
                            rem_next = head_int ? COORD_BITS'(cmd.dy_mag - cmd.dx)
                                                : cmd.dy_mag;
                            quo_next = FRAC_BITS'(head_int);
                            cnt_next = '0;
                            state_next = ST_DIV;
                        end
                    end
                    else if (active_reg)
                    begin
                        cand_next[0] = make_pix(steep_reg, col_now_reg, base_lo,
                            frame_width, frame_height,
                            COV_FULL - COV_BITS'(frac), adv_fin);
                        cand_next[1] = make_pix(steep_reg, col_now_reg, base_hi,
                            frame_width, frame_height, COV_BITS'(frac), adv_fin);
                        acc_next = acc_adv;
                        col_now_next = col_now_reg + POS_BITS'(1);
                        active_next = !adv_fin;
                        sel_next = 1'b0;
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_DIV:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    slope_next = slope_fin;
                    acc_next = acc_start;
                    col_now_next = maj0_pos + POS_BITS'(1);
                    col_stop_next = maj1_pos - POS_BITS'(1);
                    active_next = !start_fin;
                    cand_next[0] = make_pix(cmd_reg.steep, maj0_pos, min0_pos,
                        frame_width, frame_height, COV_FULL, start_fin);
                    cand_next[1] = make_pix(cmd_reg.steep, maj1_pos, min1_pos,
                        frame_width, frame_height, COV_FULL, start_fin);
                    sel_next = 1'b0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    rem_next = rem_step;
                    quo_next = {quo_reg[FRAC_BITS-2:0], quo_bit};
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_EMIT:
            begin
                if (!cand_reg[sel_reg].ok)
                begin
                    // skip a clipped pixel
                    if (sel_reg == 1'b0)
                    begin
                        sel_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (!out_valid_reg || out_ready)
                begin
                    loading = 1'b1;
                    out_valid_next = 1'b1;
                    out_item_next.pixel_x = cand_reg[sel_reg].x;
                    out_item_next.pixel_y = cand_reg[sel_reg].y;
                    out_item_next.coverage = cand_reg[sel_reg].cov;
                    out_item_next.line_finished = cand_reg[sel_reg].fin;
                    out_item_next.last = sel_reg || !cand_reg[1].ok;
                    if (sel_reg == 1'b0 && cand_reg[1].ok)
                    begin
                        sel_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg <= 1'b0;
            active_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg <= sel_next;
            active_reg <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        steep_reg <= steep_next;
        col_now_reg <= col_now_next;
        col_stop_reg <= col_stop_next;
        acc_reg <= acc_next;
        slope_reg <= slope_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        cand_reg <= cand_next;
        out_item_reg <= out_item_next;
    end

endmodule

FILE: rtl/antialiased_line_rasterizer_core.sv
// Antialiased line rasterizer, Wu style, integer endpoints.
// Input channel (in_valid/in_ready/in_item): a start item carries both
// endpoints; an advance item walks one interior column of the current line.
// Output channel (out_valid/out_ready/out_item): one pixel per item, with
// coverage 0..256; last marks the final pixel caused by an input item.
// Configuration: cfg_we/cfg_index/cfg_data write frame_width (index 0) or
// frame_height (index 1); write them only while the block is idle.
// Path: an advance item passes the command queue, the back end's candidate
// register and the output register, and either can stall it. A start item
// first runs through the serial gradient divider. The back end works on one
// item at a time; the command queue (QUEUE_DEPTH entries, two by default)
// lets the front keep accepting while the back end divides or emits.
// Reset clears the queue, the output register and the active-line flag;
// the frame size returns to 1024 x 1024.
// When the receiver stalls, the output register holds its pixel, the back
// end waits, the queue fills, and in_ready drops.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module antialiased_line_rasterizer_core #(
    parameter int FRAC_BITS = alr_pkg::DEF_FRAC_BITS,
    parameter int QUEUE_DEPTH = alr_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  alr_pkg::alr_in_t                      in_item,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output alr_pkg::alr_out_t                     out_item,
    input  logic                                  cfg_we,
    input  logic [alr_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [alr_pkg::FRAME_BITS-1:0]        cfg_data
);
    import alr_pkg::*;

    // frame size registers
    logic [FRAME_BITS-1:0] frame_width_reg;
    logic [FRAME_BITS-1:0] frame_height_reg;

    // front to queue to back
    logic                  q_push;
    alr_cmd_t              q_push_cmd;
    logic                  q_pop;
    alr_cmd_t              q_head;
    alr_queue_stat_t       q_stat;
    alr_back_stat_t        b_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= FRAME_RESET;
            frame_height_reg <= FRAME_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Classify: steep test, axis swap, endpoint ordering, deltas.
    alr_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_stat   (q_stat),
        .push     (q_push),
        .cmd      (q_push_cmd)
    );

    // Short command queue decouples acceptance from execution.
    alr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .pop      (q_pop),
        .pop_cmd  (q_head),
        .stat     (q_stat)
    );

    // Execute: serial divide on start, intercept walk on advance, clip, emit.
    alr_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .q_stat       (q_stat),
        .pop          (q_pop),
        .cmd          (q_head),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_item     (out_item),
        .stat         (b_stat)
    );

    `ASSERT_NEVER(a_queue_full_empty, clk, rst_n, q_stat.full && q_stat.empty, "queue full and empty at once")
    `ASSERT_IMPLIES(a_pop_needs_item, clk, rst_n, q_pop, !q_stat.empty, "pop from empty queue")
    `ASSERT_IMPLIES(a_no_emit_in_div, clk, rst_n, b_stat.dividing, !b_stat.loading, "pixel emitted mid-divide")
    `ASSERT_NEXT(a_load_shows_valid, clk, rst_n, b_stat.loading, out_valid, "loaded pixel not presented")

endmodule
